// ===== src/qxmm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and helpers of the quad X motor mixer.
package qxmm_pkg;

   localparam int FRAC_BITS = 12;
   localparam int ONE_Q     = 1 << FRAC_BITS;

   localparam int CMD_W    = 13;
   localparam int CORR_W   = 16;
   localparam int OFS_W    = CMD_W + 2;
   localparam int THR_W    = 2 * CMD_W - FRAC_BITS;
   localparam int THR2_W   = 16;
   localparam int MIX_W    = 18;
   localparam int SPREAD_W = MIX_W;
   localparam int NUM_W    = MIX_W + CMD_W;
   localparam int QUO_W    = MIX_W - 1;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_LAT    = DIV_STAGES + 2;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPREAD_LIMIT   = 2'd0,
      CSR_THROTTLE_ZERO  = 2'd1,
      CSR_IDLE_LEVEL     = 2'd2,
      CSR_ALLOW_INCREASE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CMD_W-1:0] spread_limit;
      logic [CMD_W-1:0] throttle_zero;
      logic [CMD_W-1:0] idle_level;
      logic             allow_increase;
   } cfg_type;

   typedef struct packed {
      logic              inverted;
      logic [CORR_W-1:0] yaw_corr;
      logic [CORR_W-1:0] pitch_corr;
      logic [CORR_W-1:0] roll_corr;
      logic [CMD_W-1:0]  throttle;
   } req_type;

   typedef logic [3:0][MIX_W-1:0] mix_vec_type;
   typedef logic [3:0][NUM_W-1:0] num_vec_type;

   typedef struct packed {
      mix_vec_type      m;
      logic [MIX_W-1:0] mn;
      logic [MIX_W-1:0] mx;
      logic             scaled;
      logic             over;
      logic             neg;
   } side_type;

   typedef struct packed {
      logic             range_scaled;
      logic [CMD_W-1:0] motor_back_left;
      logic [CMD_W-1:0] motor_back_right;
      logic [CMD_W-1:0] motor_front_left;
      logic [CMD_W-1:0] motor_front_right;
   } rsp_type;

   function automatic logic [MIX_W-1:0] smin(input logic [MIX_W-1:0] a,
                                             input logic [MIX_W-1:0] b);
      return ($signed(a) < $signed(b)) ? a : b;
   endfunction

   function automatic logic [MIX_W-1:0] smax(input logic [MIX_W-1:0] a,
                                             input logic [MIX_W-1:0] b);
      return ($signed(a) > $signed(b)) ? a : b;
   endfunction

endpackage

// ===== src/qxmm_skid.sv =====
`timescale 1ns / 1ps
// Two-entry output buffer with registered ready.
module qxmm_skid #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [DATA_W-1:0] skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== src/qxmm_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider lane with floor rounding of signed quotients.
module qxmm_div #(
   parameter int NUM_W = 31,
   parameter int DEN_W = 18,
   parameter int QUO_W = 17,
   parameter int STEPS = 2
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] num_i,
   input  logic        [DEN_W-1:0] den_i,
   output logic signed [QUO_W:0]   quo_o
);

   localparam int MAG_W = NUM_W - 1;
   localparam int REM_W = DEN_W + 1;
   localparam int ACC_W = REM_W + QUO_W;
   localparam int NST   = (QUO_W + STEPS - 1) / STEPS;

   logic [MAG_W-1:0] mag;
   logic [ACC_W-1:0] acc_ff [NST+1];
   logic [ACC_W-1:0] acc_in [NST];
   logic [DEN_W-1:0] den_ff [NST];
   logic             neg_ff [NST+1];
   logic [QUO_W-1:0] quo_mag;
   logic             rem_nz;
   logic [QUO_W:0]   quo_in;
   logic [QUO_W:0]   quo_ff;

   assign mag = num_i[NUM_W-1] ? MAG_W'(-num_i) : MAG_W'(num_i);

   always_comb begin
      for (int s = 0; s < NST; s++) begin
         acc_in[s] = acc_ff[s];
         for (int j = 0; j < STEPS; j++) begin
            if (s * STEPS + j < QUO_W) begin
               acc_in[s] = acc_in[s] << 1;
               if (acc_in[s][ACC_W-1:QUO_W] >= REM_W'(den_ff[s])) begin
                  acc_in[s][ACC_W-1:QUO_W] = acc_in[s][ACC_W-1:QUO_W] - REM_W'(den_ff[s]);
                  acc_in[s][0] = 1'b1;
               end
            end
         end
      end
   end

   assign quo_mag = acc_ff[NST][QUO_W-1:0];
   assign rem_nz  = |acc_ff[NST][ACC_W-1:QUO_W];
   assign quo_in  = neg_ff[NST] ? (~{1'b0, quo_mag}) + (QUO_W+1)'(!rem_nz)
                                : {1'b0, quo_mag};

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff[0] <= {REM_W'(mag >> QUO_W), mag[QUO_W-1:0]};
         den_ff[0] <= den_i;
         neg_ff[0] <= num_i[NUM_W-1];
         for (int s = 0; s < NST; s++) begin
            acc_ff[s+1] <= acc_in[s];
            neg_ff[s+1] <= neg_ff[s];
         end
         for (int s = 1; s < NST; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
         quo_ff <= quo_in;
      end
   end

   assign quo_o = $signed(quo_ff);

endmodule

// ===== src/qxmm_front.sv =====
`timescale 1ns / 1ps
// Throttle mapping, X mixer, min/max search and spread products.
module qxmm_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 valid_i,
   input  qxmm_pkg::req_type                    req_i,
   input  qxmm_pkg::cfg_type                    cfg_i,
   output logic                                 valid_o,
   output qxmm_pkg::side_type                   side_o,
   output qxmm_pkg::num_vec_type                num_o,
   output logic [qxmm_pkg::SPREAD_W-1:0]        spread_o
);

   localparam int CMD_W  = qxmm_pkg::CMD_W;
   localparam int OFS_W  = qxmm_pkg::OFS_W;
   localparam int THR_W  = qxmm_pkg::THR_W;
   localparam int THR2_W = qxmm_pkg::THR2_W;
   localparam int MIX_W  = qxmm_pkg::MIX_W;
   localparam int FRAC   = qxmm_pkg::FRAC_BITS;

   // stage 1: throttle times range limit
   logic [2*CMD_W-1:0]  thr_prod;
   logic                s1_valid_ff;
   logic [THR_W-1:0]    s1_thr_ff;
   qxmm_pkg::req_type   s1_req_ff;

   // stage 2: map onto throttle_zero..1
   logic signed [OFS_W-1:0]       tz_ofs;
   logic signed [THR_W+OFS_W:0]   t2_prod;
   logic signed [THR2_W-1:0]      t2_in;
   logic                          s2_valid_ff;
   logic signed [THR2_W-1:0]      s2_thr_ff;
   qxmm_pkg::req_type             s2_req_ff;

   // stage 3: mixer
   logic signed [MIX_W-1:0] te, re, pe, ye;
   qxmm_pkg::mix_vec_type   m_in;
   logic                    s3_valid_ff;
   qxmm_pkg::mix_vec_type   s3_m_ff;

   // stage 4: min and max
   logic [MIX_W-1:0]        mn_in, mx_in;
   logic                    s4_valid_ff;
   qxmm_pkg::mix_vec_type   s4_m_ff;
   logic [MIX_W-1:0]        s4_mn_ff, s4_mx_ff;

   // stage 5: spread, flags, numerators
   logic [MIX_W-1:0]                 lim_ext;
   logic [qxmm_pkg::SPREAD_W-1:0]    spread_in;
   qxmm_pkg::num_vec_type            num_in;
   logic                             s5_valid_ff;
   qxmm_pkg::side_type               s5_side_ff;
   qxmm_pkg::num_vec_type            s5_num_ff;
   logic [qxmm_pkg::SPREAD_W-1:0]    s5_spread_ff;

   assign thr_prod = req_i.throttle * cfg_i.spread_limit;

   assign tz_ofs  = signed'(OFS_W'(qxmm_pkg::ONE_Q)) - signed'(OFS_W'(cfg_i.throttle_zero));
   assign t2_prod = signed'({1'b0, s1_thr_ff}) * tz_ofs;
   assign t2_in   = THR2_W'(t2_prod >>> FRAC) + signed'(THR2_W'(cfg_i.throttle_zero));

   assign te = MIX_W'(s2_thr_ff);
   assign re = MIX_W'($signed(s2_req_ff.roll_corr));
   assign pe = MIX_W'($signed(s2_req_ff.pitch_corr));
   assign ye = MIX_W'($signed(s2_req_ff.yaw_corr));

   always_comb begin
      if (s2_req_ff.inverted) begin
         m_in[0] = te + re + pe - ye;
         m_in[1] = te - re + pe + ye;
         m_in[2] = te + re - pe + ye;
         m_in[3] = te - re - pe - ye;
      end else begin
         m_in[0] = te - re - pe + ye;
         m_in[1] = te + re - pe - ye;
         m_in[2] = te - re + pe - ye;
         m_in[3] = te + re + pe + ye;
      end
   end

   assign mn_in = qxmm_pkg::smin(qxmm_pkg::smin(s3_m_ff[0], s3_m_ff[1]),
                                 qxmm_pkg::smin(s3_m_ff[2], s3_m_ff[3]));
   assign mx_in = qxmm_pkg::smax(qxmm_pkg::smax(s3_m_ff[0], s3_m_ff[1]),
                                 qxmm_pkg::smax(s3_m_ff[2], s3_m_ff[3]));

   assign lim_ext   = MIX_W'(cfg_i.spread_limit);
   assign spread_in = s4_mx_ff - s4_mn_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         num_in[i] = $signed(s4_m_ff[i]) * $signed({1'b0, cfg_i.spread_limit});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= valid_i;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
      if (en) begin
         s1_thr_ff <= thr_prod[2*CMD_W-1:FRAC];
         s1_req_ff <= req_i;
         s2_thr_ff <= t2_in;
         s2_req_ff <= s1_req_ff;
         s3_m_ff   <= m_in;
         s4_m_ff   <= s3_m_ff;
         s4_mn_ff  <= mn_in;
         s4_mx_ff  <= mx_in;
         s5_side_ff.m      <= s4_m_ff;
         s5_side_ff.mn     <= s4_mn_ff;
         s5_side_ff.mx     <= s4_mx_ff;
         s5_side_ff.scaled <= spread_in > lim_ext;
         s5_side_ff.over   <= $signed(s4_mx_ff) > $signed(lim_ext);
         s5_side_ff.neg    <= s4_mn_ff[MIX_W-1];
         s5_num_ff    <= num_in;
         s5_spread_ff <= spread_in;
      end
   end

   assign valid_o  = s5_valid_ff;
   assign side_o   = s5_side_ff;
   assign num_o    = s5_num_ff;
   assign spread_o = s5_spread_ff;

endmodule

// ===== src/qxmm_back.sv =====
`timescale 1ns / 1ps
// Desaturation shift, clamp and idle-level mapping of the motor commands.
module qxmm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   valid_i,
   input  qxmm_pkg::side_type     side_i,
   input  qxmm_pkg::mix_vec_type  quo_i,
   input  qxmm_pkg::cfg_type      cfg_i,
   output logic                   valid_o,
   output qxmm_pkg::rsp_type      rsp_o
);

   localparam int CMD_W  = qxmm_pkg::CMD_W;
   localparam int OFS_W  = qxmm_pkg::OFS_W;
   localparam int MIX_W  = qxmm_pkg::MIX_W;
   localparam int FRAC   = qxmm_pkg::FRAC_BITS;
   localparam int PROD_W = CMD_W + 1 + OFS_W;
   localparam int V_W    = PROD_W - FRAC + 1;

   typedef logic [3:0][CMD_W-1:0]  cmd_vec_type;
   typedef logic [3:0][PROD_W-1:0] prod_vec_type;

   // stage 1: pick scaled or raw commands, work out the shift
   logic [MIX_W-1:0]        qmin;
   logic [MIX_W-1:0]        reduce_in;
   qxmm_pkg::mix_vec_type   sel_in;
   logic                    b1_valid_ff, b1_scaled_ff;
   qxmm_pkg::mix_vec_type   b1_sel_ff;
   logic [MIX_W-1:0]        b1_reduce_ff;

   // stage 2: shift and clamp
   logic                    apply;
   logic signed [MIX_W:0]   diff [4];
   cmd_vec_type             clamp_in;
   logic                    b2_valid_ff, b2_scaled_ff;
   cmd_vec_type             b2_cmd_ff;

   // stage 3: idle scaling product
   logic signed [OFS_W-1:0] io_ofs;
   prod_vec_type            prod_in;
   logic                    b3_valid_ff, b3_scaled_ff;
   prod_vec_type            b3_prod_ff;

   // stage 4: add offset and saturate
   logic signed [V_W-1:0]   v [4];
   cmd_vec_type             out_in;
   logic                    b4_valid_ff, b4_scaled_ff;
   cmd_vec_type             b4_cmd_ff;

   assign qmin = qxmm_pkg::smin(qxmm_pkg::smin(quo_i[0], quo_i[1]),
                                qxmm_pkg::smin(quo_i[2], quo_i[3]));

   always_comb begin
      if (side_i.scaled) begin
         reduce_in = qmin;
      end else if (side_i.over) begin
         reduce_in = side_i.mx - MIX_W'(cfg_i.spread_limit);
      end else if (side_i.neg) begin
         reduce_in = side_i.mn;
      end else begin
         reduce_in = '0;
      end
      for (int i = 0; i < 4; i++) begin
         sel_in[i] = side_i.scaled ? quo_i[i] : side_i.m[i];
      end
   end

   assign apply = ($signed(b1_reduce_ff) > 0) ||
                  (cfg_i.allow_increase && (b1_reduce_ff != '0));

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         diff[i] = (MIX_W+1)'($signed(b1_sel_ff[i]));
         if (apply) begin
            diff[i] = diff[i] - (MIX_W+1)'($signed(b1_reduce_ff));
         end
         if (diff[i] < 0) begin
            clamp_in[i] = '0;
         end else if (diff[i] > (MIX_W+1)'(qxmm_pkg::ONE_Q)) begin
            clamp_in[i] = CMD_W'(qxmm_pkg::ONE_Q);
         end else begin
            clamp_in[i] = diff[i][CMD_W-1:0];
         end
      end
   end

   assign io_ofs = signed'(OFS_W'(qxmm_pkg::ONE_Q)) - signed'(OFS_W'(cfg_i.idle_level));

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = signed'({1'b0, b2_cmd_ff[i]}) * io_ofs;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         v[i] = V_W'($signed(b3_prod_ff[i]) >>> FRAC) + signed'(V_W'(cfg_i.idle_level));
         if (v[i] < 0) begin
            out_in[i] = '0;
         end else if (|v[i][V_W-2:CMD_W]) begin
            out_in[i] = '1;
         end else begin
            out_in[i] = v[i][CMD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff <= valid_i;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end
      if (en) begin
         b1_scaled_ff <= side_i.scaled;
         b1_sel_ff    <= sel_in;
         b1_reduce_ff <= reduce_in;
         b2_scaled_ff <= b1_scaled_ff;
         b2_cmd_ff    <= clamp_in;
         b3_scaled_ff <= b2_scaled_ff;
         b3_prod_ff   <= prod_in;
         b4_scaled_ff <= b3_scaled_ff;
         b4_cmd_ff    <= out_in;
      end
   end

   assign valid_o                 = b4_valid_ff;
   assign rsp_o.motor_front_right = b4_cmd_ff[0];
   assign rsp_o.motor_front_left  = b4_cmd_ff[1];
   assign rsp_o.motor_back_right  = b4_cmd_ff[2];
   assign rsp_o.motor_back_left   = b4_cmd_ff[3];
   assign rsp_o.range_scaled      = b4_scaled_ff;

endmodule

// ===== src/quad_x_motor_mixer_top.sv =====
`timescale 1ns / 1ps
// Quad X motor mixer with desaturation, top level.
//
// Takes one sample per clock when the result side does not stall and returns
// the four motor commands through five front stages (throttle scaling,
// throttle mapping, mixer, min/max, spread and products), four pipelined
// restoring dividers that work two quotient bits per stage, four back stages
// (shift, clamp, idle product, offset and saturate) and the output register.
// The dividers always run; their quotients are used only when the spread
// exceeds the limit. When the result side stalls and a further result
// arrives, req_tready (registered in the output buffer) drops and nothing is lost.
// Configuration writes take effect at once and belong to idle periods.
module quad_x_motor_mixer_top (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: throttle[12:0], roll_corr[28:13], pitch_corr[44:29],
   //        yaw_corr[60:45], zero[63:61]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [qxmm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: inverted
   input  logic                                req_tuser,
   // tdata: motor_front_right[12:0], motor_front_left[25:13],
   //        motor_back_right[38:26], motor_back_left[51:39], zero[55:52]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [qxmm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: range_scaled
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [qxmm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qxmm_pkg::CMD_W-1:0]          csr_wdata
);

   localparam int CMD_W   = qxmm_pkg::CMD_W;
   localparam int CORR_W  = qxmm_pkg::CORR_W;
   localparam int DIV_LAT = qxmm_pkg::DIV_LAT;
   localparam int RSP_W   = $bits(qxmm_pkg::rsp_type);

   qxmm_pkg::cfg_type      cfg_ff;
   qxmm_pkg::req_type      req;
   logic                   en;

   logic                   front_valid;
   qxmm_pkg::side_type     front_side;
   qxmm_pkg::num_vec_type  front_num;
   logic [qxmm_pkg::SPREAD_W-1:0] front_spread;

   qxmm_pkg::mix_vec_type  quo;
   logic [DIV_LAT-1:0]     dvalid_ff;
   qxmm_pkg::side_type     side_ff [DIV_LAT];

   logic                   back_valid;
   qxmm_pkg::rsp_type      back_rsp;
   qxmm_pkg::rsp_type      out_rsp;
   logic [RSP_W-1:0]       out_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spread_limit   <= CMD_W'(qxmm_pkg::ONE_Q);
         cfg_ff.throttle_zero  <= '0;
         cfg_ff.idle_level     <= '0;
         cfg_ff.allow_increase <= 1'b0;
      end else if (csr_we) begin
         case (qxmm_pkg::csr_index_type'(csr_index))
            qxmm_pkg::CSR_SPREAD_LIMIT:   cfg_ff.spread_limit   <= csr_wdata;
            qxmm_pkg::CSR_THROTTLE_ZERO:  cfg_ff.throttle_zero  <= csr_wdata;
            qxmm_pkg::CSR_IDLE_LEVEL:     cfg_ff.idle_level     <= csr_wdata;
            qxmm_pkg::CSR_ALLOW_INCREASE: cfg_ff.allow_increase <= csr_wdata[0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign req.throttle   = req_tdata[CMD_W-1:0];
   assign req.roll_corr  = req_tdata[CMD_W +: CORR_W];
   assign req.pitch_corr = req_tdata[CMD_W+CORR_W +: CORR_W];
   assign req.yaw_corr   = req_tdata[CMD_W+2*CORR_W +: CORR_W];
   assign req.inverted   = req_tuser;

   assign req_tready = en;

   qxmm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .valid_i  (req_tvalid),
      .req_i    (req),
      .cfg_i    (cfg_ff),
      .valid_o  (front_valid),
      .side_o   (front_side),
      .num_o    (front_num),
      .spread_o (front_spread)
   );

   for (genvar i = 0; i < 4; i++) begin : g_div
      logic signed [qxmm_pkg::QUO_W:0] lane_quo;

      qxmm_div #(
         .NUM_W (qxmm_pkg::NUM_W),
         .DEN_W (qxmm_pkg::SPREAD_W),
         .QUO_W (qxmm_pkg::QUO_W),
         .STEPS (qxmm_pkg::DIV_STEPS)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num_i ($signed(front_num[i])),
         .den_i (front_spread),
         .quo_o (lane_quo)
      );

      assign quo[i] = lane_quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff <= '0;
      end else if (en) begin
         dvalid_ff <= {dvalid_ff[DIV_LAT-2:0], front_valid};
      end
      if (en) begin
         side_ff[0] <= front_side;
         for (int k = 1; k < DIV_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   qxmm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (dvalid_ff[DIV_LAT-1]),
      .side_i  (side_ff[DIV_LAT-1]),
      .quo_i   (quo),
      .cfg_i   (cfg_ff),
      .valid_o (back_valid),
      .rsp_o   (back_rsp)
   );

   qxmm_skid #(
      .DATA_W (RSP_W)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (back_valid),
      .in_ready  (en),
      .in_data   (back_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_bits)
   );

   assign out_rsp   = qxmm_pkg::rsp_type'(out_bits);
   assign rsp_tdata = {(qxmm_pkg::RSP_DATA_W - 4*CMD_W)'(0),
                       out_rsp.motor_back_left, out_rsp.motor_back_right,
                       out_rsp.motor_front_left, out_rsp.motor_front_right};
   assign rsp_tuser = out_rsp.range_scaled;

endmodule
